// File: src/source_line_comment_counter_top_assert.svh
// Assertion macros for the source line comment counter.
// Used by source_line_comment_counter_top; needs no other file.
`ifndef SOURCE_LINE_COMMENT_COUNTER_TOP_ASSERT_SVH
`define SOURCE_LINE_COMMENT_COUNTER_TOP_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define SLCC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slcc assertion failed");

// Antecedent implies consequent in the next cycle.
`define SLCC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slcc assertion failed");

`endif

// File: src/slcc_pkg.sv
// Shared types, codes and the per-byte scan function of the line comment counter.
// No dependencies; used by slcc_core and source_line_comment_counter_top.
package slcc_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int OUT_WIDTH       = 32;

  typedef logic [2:0] kind_t;

  localparam kind_t KIND_NEWLINE = 3'd0;
  localparam kind_t KIND_LINE    = 3'd1;
  localparam kind_t KIND_START   = 3'd2;
  localparam kind_t KIND_END     = 3'd3;
  localparam kind_t KIND_OTHER   = 3'd4;
  localparam kind_t KIND_NONE    = 3'd7;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;

  typedef struct packed {
    logic [7:0] held_byte;
    logic       held_valid;
    logic       in_quote;
    kind_t      newest_kind;
    logic       have_token;
    logic       pending_is_first;
    kind_t      before_kind;
    logic       block_scope;
  } scan_t;

  localparam scan_t SCAN_RESET = '{
    held_byte:        8'h00,
    held_valid:       1'b0,
    in_quote:         1'b0,
    newest_kind:      KIND_NEWLINE,
    have_token:       1'b0,
    pending_is_first: 1'b1,
    before_kind:      KIND_NONE,
    block_scope:      1'b0
  };

  typedef struct packed {
    scan_t      st;
    logic       consumed;
    logic       inc_line;
    logic [1:0] inc_blank;
    logic       inc_comment;
  } judge_t;

  typedef struct packed {
    logic [OUT_WIDTH-1:0] line_total;
    logic [OUT_WIDTH-1:0] blank_total;
    logic [OUT_WIDTH-1:0] comment_total;
  } result_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) ||
           (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

  // Judge byte c with lookahead n. A new token scores the one before it.
  function automatic judge_t slcc_judge(scan_t st, logic [7:0] c, logic [7:0] n);
    judge_t r;
    logic   emit_en;
    kind_t  kind;
    logic   at_start;
    r             = '0;
    r.st          = st;
    emit_en       = 1'b0;
    kind          = KIND_OTHER;
    case (st.newest_kind)
      KIND_LINE: begin
        if (c == CH_NL) begin
          emit_en = 1'b1;
          kind    = KIND_NEWLINE;
        end
      end
      KIND_START: begin
        if (c == CH_NL) begin
          emit_en = 1'b1;
          kind    = KIND_NEWLINE;
        end else if (c == CH_STAR && n == CH_SLASH) begin
          emit_en    = 1'b1;
          kind       = KIND_END;
          r.consumed = 1'b1;
        end
      end
      default: begin
        if (is_space(c)) begin
          if (c == CH_NL) begin
            emit_en = 1'b1;
            kind    = KIND_NEWLINE;
          end
        end else if (st.in_quote) begin
          if (c == CH_DQUOTE) r.st.in_quote = 1'b0;
        end else if (c == CH_SQUOTE) begin
          r.consumed = 1'b1;
        end else if (c == CH_DQUOTE) begin
          r.st.in_quote = 1'b1;
        end else if (c == CH_SLASH && n == CH_SLASH) begin
          emit_en    = 1'b1;
          kind       = KIND_LINE;
          r.consumed = 1'b1;
        end else if (c == CH_SLASH && n == CH_STAR) begin
          emit_en    = 1'b1;
          kind       = KIND_START;
          r.consumed = 1'b1;
        end else if (c == CH_STAR && n == CH_SLASH) begin
          emit_en    = 1'b1;
          kind       = KIND_END;
          r.consumed = 1'b1;
        end else if (st.newest_kind != KIND_OTHER) begin
          emit_en = 1'b1;
          kind    = KIND_OTHER;
        end
      end
    endcase

    at_start = st.pending_is_first || (st.before_kind == KIND_NEWLINE);
    if (emit_en) begin
      if (st.have_token) begin
        case (st.newest_kind)
          KIND_NEWLINE: begin
            r.inc_line  = 1'b1;
            r.inc_blank = {1'b0, st.pending_is_first} + {1'b0, kind == KIND_NEWLINE};
            r.inc_comment = (kind != KIND_NEWLINE) && st.block_scope;
          end
          KIND_LINE: begin
            r.inc_comment = !st.block_scope && at_start;
          end
          KIND_START: begin
            r.inc_comment    = !st.block_scope && at_start;
            r.st.block_scope = 1'b1;
          end
          KIND_END: begin
            r.st.block_scope = 1'b0;
          end
          default: begin
          end
        endcase
        r.st.before_kind      = st.newest_kind;
        r.st.pending_is_first = 1'b0;
      end else begin
        r.st.have_token       = 1'b1;
        r.st.pending_is_first = 1'b1;
        r.st.before_kind      = KIND_NONE;
      end
      r.st.newest_kind = kind;
    end
    return r;
  endfunction

endpackage

// File: src/slcc_core.sv
// Scan state and saturating line counters of the line comment counter.
// Depends on slcc_pkg; the result appears combinationally on a final byte.
module slcc_core
  import slcc_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] text_byte,
  input  logic       is_final,
  output logic       res_valid,
  output result_t    res
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

  scan_t                  scan;
  scan_t                  scan_mid;
  logic [COUNT_WIDTH-1:0] line_count;
  logic [COUNT_WIDTH-1:0] blank_count;
  logic [COUNT_WIDTH-1:0] comment_count;
  logic [COUNT_WIDTH-1:0] line_count_next;
  logic [COUNT_WIDTH-1:0] blank_count_next;
  logic [COUNT_WIDTH-1:0] comment_count_next;

  judge_t     j_first;
  judge_t     j_last;
  logic       use_first;
  logic       use_last;
  logic [1:0] inc_line;
  logic [2:0] inc_blank;
  logic [1:0] inc_comment;

  // Repeated saturating bumps collapse into one clamped add.
  function automatic logic [COUNT_WIDTH-1:0] sat_add(logic [COUNT_WIDTH-1:0] v,
                                                     logic [2:0] inc);
    logic [COUNT_WIDTH:0] sum;
    sum = {1'b0, v} + (COUNT_WIDTH + 1)'(inc);
    return sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
  endfunction

  always_comb begin
    use_first = scan.held_valid;
    j_first   = slcc_judge(scan, scan.held_byte, text_byte);
    if (!use_first) begin
      scan_mid            = scan;
      scan_mid.held_byte  = text_byte;
      scan_mid.held_valid = 1'b1;
    end else if (j_first.consumed) begin
      scan_mid            = j_first.st;
      scan_mid.held_valid = 1'b0;
    end else begin
      scan_mid           = j_first.st;
      scan_mid.held_byte = text_byte;
    end
    // On the last byte the held byte is judged against a zero lookahead.
    use_last = is_final && scan_mid.held_valid;
    j_last   = slcc_judge(scan_mid, scan_mid.held_byte, CH_NUL);

    inc_line    = {1'b0, use_first & j_first.inc_line} + {1'b0, use_last & j_last.inc_line};
    inc_blank   = {1'b0, use_first ? j_first.inc_blank : 2'b00}
                + {1'b0, use_last ? j_last.inc_blank : 2'b00};
    inc_comment = {1'b0, use_first & j_first.inc_comment}
                + {1'b0, use_last & j_last.inc_comment};

    line_count_next    = sat_add(line_count, {1'b0, inc_line});
    blank_count_next   = sat_add(blank_count, inc_blank);
    comment_count_next = sat_add(comment_count, {1'b0, inc_comment});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan          <= SCAN_RESET;
      line_count    <= COUNT_ONE;
      blank_count   <= '0;
      comment_count <= '0;
    end else if (accept) begin
      if (is_final) begin
        scan          <= SCAN_RESET;
        line_count    <= COUNT_ONE;
        blank_count   <= '0;
        comment_count <= '0;
      end else begin
        scan          <= scan_mid;
        line_count    <= line_count_next;
        blank_count   <= blank_count_next;
        comment_count <= comment_count_next;
      end
    end
  end

  assign res_valid = accept && is_final;

  generate
    if (COUNT_WIDTH >= OUT_WIDTH) begin : g_trunc
      assign res.line_total    = line_count_next[OUT_WIDTH-1:0];
      assign res.blank_total   = blank_count_next[OUT_WIDTH-1:0];
      assign res.comment_total = comment_count_next[OUT_WIDTH-1:0];
    end else begin : g_ext
      assign res.line_total    = {{(OUT_WIDTH-COUNT_WIDTH){1'b0}}, line_count_next};
      assign res.blank_total   = {{(OUT_WIDTH-COUNT_WIDTH){1'b0}}, blank_count_next};
      assign res.comment_total = {{(OUT_WIDTH-COUNT_WIDTH){1'b0}}, comment_count_next};
    end
  endgenerate

endmodule

// File: src/source_line_comment_counter_top.sv
// Top level of the source line comment counter: scan core plus output skid buffer.
// Depends on slcc_pkg, slcc_core and source_line_comment_counter_top_assert.svh.
//
// Usage:
//   Input channel (in_valid, in_stall, text_byte, is_final) carries one byte of
//   C source per transfer; is_final marks the last byte of a file.
//   Output channel (out_valid, out_stall, line_total, blank_total,
//   comment_total) carries one result per file: total, blank and comment
//   line counts, each saturating at 2^COUNT_WIDTH - 1 and shown as 32 bits.
//   Throughput: one byte per cycle while in_stall is low. The scan state updates
//   in the cycle a byte is taken; the result of a final byte is registered and
//   shows on out_valid from the output register, or first waits in the skid.
//   When the receiver stalls, the result holds in the output register and
//   bytes keep flowing; a second result parks in a skid register, and only
//   then is in_stall raised until the output drains.
//   Reset (rst, synchronous) clears the scan state, sets the counts to one,
//   zero and zero and empties the output. After each final byte the scan
//   state returns to that same reset state for the next file.
`include "source_line_comment_counter_top_assert.svh"

module source_line_comment_counter_top
  import slcc_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           text_byte,
  input  logic                 is_final,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUT_WIDTH-1:0] line_total,
  output logic [OUT_WIDTH-1:0] blank_total,
  output logic [OUT_WIDTH-1:0] comment_total
);

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t main_res;
  result_t skid_res;
  logic    skid_valid;
  logic    out_fire;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  slcc_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .text_byte (text_byte),
    .is_final  (is_final),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_fire) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_fire) begin
      main_res <= skid_valid ? skid_res : res;
    end else if (res_valid) begin
      skid_res <= res;
    end
  end

  assign line_total    = main_res.line_total;
  assign blank_total   = main_res.blank_total;
  assign comment_total = main_res.comment_total;

  // The skid only fills behind a held result.
  `SLCC_ASSERT_NOW(a_skid_behind_main, clk, rst, skid_valid, out_valid)
  // No new result may arrive while the skid is occupied.
  `SLCC_ASSERT_NOW(a_no_result_when_full, clk, rst, res_valid, !skid_valid)
  // A draining output moves the skid entry forward and frees the input.
  `SLCC_ASSERT_NEXT(a_skid_drains, clk, rst, skid_valid && !out_stall,
                    out_valid && !skid_valid)

endmodule
